>>> sv/huffman_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// Huffman stream decoder assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_STREAM_DECODER_DEFINES_SVH
`define HUFFMAN_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// cond holds at every clock edge outside reset
`define HSD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// ante implies cons through a non-overlapping implication
`define HSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HSD_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define HSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> sv/hsd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman stream decoder package
// Sizes, codes and channel types shared by the decoder modules.
// ----------------------------------------------------------------------------
package hsd_pkg;

   // tree store sizing
   localparam int NODE_COUNT   = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 128;
   localparam int BYTE_BITS    = 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int USED_W = $clog2(NODE_COUNT + 1);
   localparam int ROW_W  = 2 * NODE_W;
   localparam int LEAF_W = $clog2(SYMBOL_COUNT);

   // field widths
   localparam int FUNC_W     = 2;
   localparam int SYM_W      = 7;
   localparam int LEN_W      = 6;
   localparam int CODE_W     = 32;
   localparam int CODE_IDX_W = $clog2(CODE_W);
   localparam int CNT_W      = 4;
   localparam int STATUS_W   = 2;
   localparam int OP_W       = 3;

   // func codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

   // classified operations carried through the queue
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
   localparam logic [OP_W-1:0] OP_BADLEN = 3'd3;
   localparam logic [OP_W-1:0] OP_DECODE = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  code_len;
      logic [CODE_W-1:0] code_bits;
      logic [BYTE_BITS-1:0] data_byte;
      logic [CNT_W-1:0]  bit_count;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0]    out_symbol;
      logic                symbol_valid;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [SYM_W-1:0]     symbol;
      logic [LEN_W-1:0]     code_len;
      logic [CODE_W-1:0]    code_bits;
      logic [BYTE_BITS-1:0] data_byte;
      logic [CNT_W-1:0]     bit_cnt;
   } cmd_type;

   typedef struct packed {
      logic [USED_W-1:0] nodes_used;
      logic [NODE_W-1:0] walk_node;
      logic              idle;
   } bk_status_type;

endpackage

>>> sv/hsd_front.sv
// ----------------------------------------------------------------------------
// Huffman stream decoder front end
// Accepts request transfers, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module hsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hsd_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output hsd_pkg::cmd_type  cmd
);

   localparam int QPTR_W = (hsd_pkg::QUEUE_DEPTH > 1) ? $clog2(hsd_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(hsd_pkg::QUEUE_DEPTH + 1);

   hsd_pkg::cmd_type  queue_ff [hsd_pkg::QUEUE_DEPTH];
   hsd_pkg::cmd_type  item;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(hsd_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // classify: fold length checks and bit count saturation in up front
   always_comb begin
      item           = '0;
      item.symbol    = req_data.symbol;
      item.code_len  = req_data.code_len;
      item.code_bits = req_data.code_bits;
      item.data_byte = req_data.data_byte;
      case (req_data.func)
         hsd_pkg::FUNC_CLEAR: begin
            item.op = hsd_pkg::OP_CLEAR;
         end
         hsd_pkg::FUNC_LOAD: begin
            if (req_data.code_len == '0 ||
                32'(req_data.code_len) > hsd_pkg::MAX_CODE_LEN) begin
               item.op = hsd_pkg::OP_BADLEN;
            end else begin
               item.op = hsd_pkg::OP_LOAD;
            end
         end
         hsd_pkg::FUNC_DECODE: begin
            item.op = hsd_pkg::OP_DECODE;
         end
         default: begin
            item.op = hsd_pkg::OP_NONE;
         end
      endcase
      if (32'(req_data.bit_count) > hsd_pkg::BYTE_BITS) begin
         item.bit_cnt = hsd_pkg::CNT_W'(hsd_pkg::BYTE_BITS);
      end else begin
         item.bit_cnt = req_data.bit_count;
      end
   end

   assign req_stall = (count_ff == QCNT_W'(hsd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> sv/hsd_back.sv
// ----------------------------------------------------------------------------
// Huffman stream decoder back end
// Runs clear, load and decode commands on the node store; owns the rsp register.
// ----------------------------------------------------------------------------
module hsd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  hsd_pkg::cmd_type       cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hsd_pkg::rsp_type       rsp_data,
   output hsd_pkg::bk_status_type status
);

   localparam int NODE_W = hsd_pkg::NODE_W;
   localparam int ROW_W  = hsd_pkg::ROW_W;
   localparam int LEN_W  = hsd_pkg::LEN_W;
   localparam int USED_W = hsd_pkg::USED_W;
   localparam int SUM_W  = ((USED_W > LEN_W) ? USED_W : LEN_W) + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_LD_WALK  = 3'd1;
   localparam logic [2:0] S_LD_MAKE  = 3'd2;
   localparam logic [2:0] S_LD_LEAF  = 3'd3;
   localparam logic [2:0] S_DC_CHILD = 3'd4;
   localparam logic [2:0] S_DC_LEAF  = 3'd5;
   localparam logic [2:0] S_FIN      = 3'd6;

   // node store: one row {left, right} per node, valid bit per row
   logic [ROW_W-1:0]               child_mem [hsd_pkg::NODE_COUNT];
   logic [hsd_pkg::LEAF_W-1:0]     leaf_mem  [hsd_pkg::NODE_COUNT];
   logic [hsd_pkg::NODE_COUNT-1:0] valid_ff, valid_in;
   logic [ROW_W-1:0]               row_rd_ff;
   logic                           row_vld_ff;
   logic [hsd_pkg::LEAF_W-1:0]     leaf_rd_ff;
   logic [ROW_W-1:0]               row;

   logic [NODE_W-1:0]          rd_addr;
   logic                       wr_en;
   logic [NODE_W-1:0]          wr_addr;
   logic [ROW_W-1:0]           wr_row;
   logic                       leaf_wr_en;
   logic                       clr;

   logic [2:0]                 state_ff, state_in;
   hsd_pkg::cmd_type           cmd_ff, cmd_in;
   logic [NODE_W-1:0]          node_ff, node_in;
   logic [LEN_W-1:0]           depth_ff, depth_in;
   logic                       first_ff, first_in;
   logic [ROW_W-1:0]           prow_ff, prow_in;
   logic [USED_W-1:0]          used_ff, used_in;
   logic [NODE_W-1:0]          walk_ff, walk_in;
   logic [NODE_W-1:0]          cand_ff, cand_in;
   logic [hsd_pkg::BYTE_BITS-1:0] sh_ff, sh_in;
   logic [hsd_pkg::CNT_W-1:0]  left_ff, left_in;
   hsd_pkg::rsp_type           pend_ff, pend_in;
   logic                       pend_ok_ff, pend_ok_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   hsd_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                       out_free;
   logic                       emit_ok;
   logic                       emit;
   hsd_pkg::rsp_type           emit_data;
   logic                       push;
   hsd_pkg::rsp_type           push_data;

   function automatic logic [NODE_W-1:0] child_sel(input logic [ROW_W-1:0] r,
                                                   input logic bit_v);
      logic [NODE_W-1:0] c;
      c = bit_v ? r[NODE_W-1:0] : r[ROW_W-1:NODE_W];
      return c;
   endfunction

   function automatic logic [ROW_W-1:0] with_child(input logic [ROW_W-1:0] r,
                                                   input logic bit_v,
                                                   input logic [NODE_W-1:0] n);
      logic [ROW_W-1:0] w;
      w = r;
      if (bit_v) begin
         w[NODE_W-1:0] = n;
      end else begin
         w[ROW_W-1:NODE_W] = n;
      end
      return w;
   endfunction

   // code bit at the given depth, most significant used bit first
   function automatic logic code_bit(input logic [hsd_pkg::CODE_W-1:0] bits,
                                     input logic [LEN_W-1:0] len,
                                     input logic [LEN_W-1:0] depth);
      logic [LEN_W-1:0] pos;
      logic             r;
      pos = len - depth - 1'b1;
      r   = 1'b0;
      if (32'(pos) < hsd_pkg::CODE_W) begin
         r = bits[pos[hsd_pkg::CODE_IDX_W-1:0]];
      end
      return r;
   endfunction

   assign row      = row_vld_ff ? row_rd_ff : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_ok  = !pend_ok_ff || out_free;

   always_comb begin
      logic [NODE_W-1:0] c;
      logic              b;
      logic [SUM_W-1:0]  need;

      state_in   = state_ff;
      cmd_in     = cmd_ff;
      node_in    = node_ff;
      depth_in   = depth_ff;
      first_in   = first_ff;
      prow_in    = prow_ff;
      used_in    = used_ff;
      walk_in    = walk_ff;
      cand_in    = cand_ff;
      sh_in      = sh_ff;
      left_in    = left_ff;
      pend_in    = pend_ff;
      pend_ok_in = pend_ok_ff;
      cmd_pop    = 1'b0;
      rd_addr    = walk_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_row     = '0;
      leaf_wr_en = 1'b0;
      clr        = 1'b0;
      emit       = 1'b0;
      emit_data  = '0;
      push       = 1'b0;
      push_data  = '0;
      c          = '0;
      b          = 1'b0;
      need       = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               case (cmd.op)
                  hsd_pkg::OP_CLEAR: begin
                     clr      = 1'b1;
                     used_in  = USED_W'(1);
                     walk_in  = '0;
                     state_in = S_FIN;
                  end
                  hsd_pkg::OP_LOAD: begin
                     node_in  = '0;
                     depth_in = '0;
                     rd_addr  = '0;
                     state_in = S_LD_WALK;
                  end
                  hsd_pkg::OP_BADLEN: begin
                     pend_in        = '0;
                     pend_in.status = hsd_pkg::ST_TOO_LONG;
                     pend_ok_in     = 1'b1;
                     state_in       = S_FIN;
                  end
                  hsd_pkg::OP_DECODE: begin
                     sh_in   = cmd.data_byte;
                     left_in = cmd.bit_cnt;
                     if (cmd.bit_cnt == '0) begin
                        state_in = S_FIN;
                     end else begin
                        state_in = S_DC_CHILD;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         // follow existing nodes along the code
         S_LD_WALK: begin
            rd_addr = node_ff;
            if (depth_ff == cmd_ff.code_len) begin
               state_in = S_LD_LEAF;
            end else begin
               b = code_bit(cmd_ff.code_bits, cmd_ff.code_len, depth_ff);
               c = child_sel(row, b);
               if (c != '0) begin
                  node_in  = c;
                  depth_in = depth_ff + 1'b1;
                  rd_addr  = c;
               end else begin
                  prow_in  = row;
                  first_in = 1'b1;
                  need     = SUM_W'(used_ff) + SUM_W'(cmd_ff.code_len - depth_ff);
                  if (need > SUM_W'(hsd_pkg::NODE_COUNT)) begin
                     pend_in        = '0;
                     pend_in.status = hsd_pkg::ST_FULL;
                     pend_ok_in     = 1'b1;
                     state_in       = S_FIN;
                  end else begin
                     state_in = S_LD_MAKE;
                  end
               end
            end
         end

         // append one new node per cycle and link it to its parent
         S_LD_MAKE: begin
            rd_addr  = node_ff;
            b        = code_bit(cmd_ff.code_bits, cmd_ff.code_len, depth_ff);
            wr_en    = 1'b1;
            wr_addr  = node_ff;
            wr_row   = with_child(first_ff ? prow_ff : '0, b, used_ff[NODE_W-1:0]);
            used_in  = used_ff + 1'b1;
            node_in  = used_ff[NODE_W-1:0];
            depth_in = depth_ff + 1'b1;
            first_in = 1'b0;
            if (depth_ff + 1'b1 == cmd_ff.code_len) begin
               state_in = S_LD_LEAF;
            end
         end

         S_LD_LEAF: begin
            leaf_wr_en = 1'b1;
            state_in   = S_FIN;
         end

         // row of the walk node is on hand: take the child for the next bit
         S_DC_CHILD: begin
            rd_addr = walk_ff;
            c = child_sel(row, sh_ff[hsd_pkg::BYTE_BITS-1]);
            if (c == '0) begin
               if (emit_ok) begin
                  emit             = 1'b1;
                  emit_data.status = hsd_pkg::ST_MISSING;
                  walk_in          = '0;
                  sh_in            = sh_ff << 1;
                  left_in          = left_ff - 1'b1;
                  rd_addr          = '0;
                  if (left_ff == hsd_pkg::CNT_W'(1)) begin
                     state_in = S_FIN;
                  end
               end
            end else begin
               cand_in  = c;
               rd_addr  = c;
               state_in = S_DC_LEAF;
            end
         end

         // row of the child is on hand: leaf emits, inner node becomes walk node
         S_DC_LEAF: begin
            rd_addr = cand_ff;
            if (row == '0) begin
               if (emit_ok) begin
                  emit                   = 1'b1;
                  emit_data.out_symbol   = hsd_pkg::SYM_W'(leaf_rd_ff);
                  emit_data.symbol_valid = 1'b1;
                  emit_data.status       = hsd_pkg::ST_OK;
                  walk_in                = '0;
                  sh_in                  = sh_ff << 1;
                  left_in                = left_ff - 1'b1;
                  rd_addr                = '0;
                  if (left_ff == hsd_pkg::CNT_W'(1)) begin
                     state_in = S_FIN;
                  end else begin
                     state_in = S_DC_CHILD;
                  end
               end
            end else begin
               walk_in = cand_ff;
               sh_in   = sh_ff << 1;
               left_in = left_ff - 1'b1;
               if (left_ff == hsd_pkg::CNT_W'(1)) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_DC_CHILD;
               end
            end
         end

         // close the item: held result, or an empty one, goes out marked last
         S_FIN: begin
            if (out_free) begin
               push = 1'b1;
               if (pend_ok_ff) begin
                  push_data = pend_ff;
               end
               push_data.last = 1'b1;
               pend_ok_in     = 1'b0;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold each new result back until the next one or the finish so the final one can carry last
      if (emit) begin
         push       = pend_ok_ff;
         push_data  = pend_ff;
         pend_in    = emit_data;
         pend_ok_in = 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clr) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rsp_valid_in = push || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = push ? push_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         child_mem[wr_addr] <= wr_row;
      end
      if (leaf_wr_en) begin
         leaf_mem[node_ff] <= hsd_pkg::LEAF_W'(cmd_ff.symbol);
      end
      row_rd_ff  <= child_mem[rd_addr];
      row_vld_ff <= valid_ff[rd_addr];
      leaf_rd_ff <= leaf_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= USED_W'(1);
         walk_ff      <= '0;
         pend_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         walk_ff      <= walk_in;
         pend_ok_ff   <= pend_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      cmd_ff      <= cmd_in;
      node_ff     <= node_in;
      depth_ff    <= depth_in;
      first_ff    <= first_in;
      prow_ff     <= prow_in;
      cand_ff     <= cand_in;
      sh_ff       <= sh_in;
      left_ff     <= left_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;
   assign status.nodes_used = used_ff;
   assign status.walk_node  = walk_ff;
   assign status.idle       = (state_ff == S_IDLE);

endmodule

>>> sv/huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// Huffman stream decoder
// Code tree builder and bit-serial tree walker over a node store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: clear the tree, load one code
//   (symbol, length, bits) or decode one byte with its valid bit count.
//   rsp_* returns the results; the final result of each item has last set.
//   Clear, load and unused func codes give one result; a decode gives one
//   result per symbol or missing child, or a single empty one if none.
// Timing:
//   A two-entry queue takes items while the back end works. Each item is
//   taken in the idle state and closed in a finish state. A load walks one
//   node per cycle and creates one node per cycle. A decode reads the node
//   store twice per bit (once for the bit and once for the child), once
//   for a missing child. The node store read port sets the decode pace.
// Reset and stall:
//   Reset empties the queue and leaves only the root; clears need no sweep
//   of the store. When rsp_stall is high the output register holds, one
//   more result waits inside, and the walk then stops until the output drains.
// ----------------------------------------------------------------------------
`include "huffman_stream_decoder_defines.svh"

module huffman_stream_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hsd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hsd_pkg::rsp_type rsp_data
);

   // queue between front and back
   hsd_pkg::cmd_type       cmd;
   logic                   cmd_valid;
   logic                   cmd_pop;
   hsd_pkg::bk_status_type bk_stat;

   // classify and queue incoming transfers
   hsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   // execute commands on the tree and drive results
   hsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (bk_stat)
   );

   // checks
   localparam int USED_W_EXT = hsd_pkg::USED_W;

   logic sym_ok;
   logic used_ok;
   logic walk_ok;

   // a decoded symbol is never reported together with an error
   assign sym_ok  = !rsp_valid || !rsp_data.symbol_valid ||
                    (rsp_data.status == hsd_pkg::ST_OK);
   // fill count stays within the store, root always present
   assign used_ok = (bk_stat.nodes_used != '0) &&
                    (32'(bk_stat.nodes_used) <= hsd_pkg::NODE_COUNT);
   // walk pointer only ever names an allocated node
   assign walk_ok = (USED_W_EXT'(bk_stat.walk_node) < bk_stat.nodes_used);

   `HSD_ASSERT_ALWAYS(a_sym_ok, clock, reset, sym_ok, "symbol reported with error")
   `HSD_ASSERT_ALWAYS(a_used_ok, clock, reset, used_ok, "node count out of range")
   `HSD_ASSERT_ALWAYS(a_walk_ok, clock, reset, walk_ok, "walk node not allocated")
   `HSD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && bk_stat.idle, "not idle")

endmodule

>>> tb/huffman_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// Huffman stream decoder testbench
// Drives clear, load and decode items through the request channel and
// compares every result against a tree-walking predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_tb;
   import hsd_pkg::*;

   // func value with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // receiver stall patterns
   localparam int STALL_NONE     = 0;
   localparam int STALL_SPRINKLE = 1;
   localparam int STALL_LONG     = 2;

   localparam int RANDOM_ITEMS = 125;
   localparam int MID_PAUSE_AT = 60;
   // cycles without any transfer before the run is declared hung
   localparam int IDLE_LIMIT   = 1000;
   // settle time after the last result, well above the longest decode
   localparam int TAIL_CYCLES  = 40;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the node store plus the queue of results due
   // -------------------------------------------------------------------------
   class tree_scoreboard;
      logic [NODE_W-1:0] left_of   [NODE_COUNT];
      logic [NODE_W-1:0] right_of  [NODE_COUNT];
      logic [SYM_W-1:0]  symbol_at [NODE_COUNT];
      int                node_fill;
      logic [NODE_W-1:0] walk_at;
      rsp_type           due_results[$];
      int                mismatches;
      int                items_seen;
      int                decodes_seen;
      int                symbols_seen;
      int                status_seen[4];

      function new();
         mismatches   = 0;
         items_seen   = 0;
         decodes_seen = 0;
         symbols_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         wipe_tree();
      endfunction

      function void wipe_tree();
         foreach (left_of[i]) begin
            left_of[i]   = '0;
            right_of[i]  = '0;
            symbol_at[i] = '0;
         end
         node_fill = 1;
         walk_at   = '0;
      endfunction

      function rsp_type make_result(logic [SYM_W-1:0] sym, logic hit,
                                    logic [STATUS_W-1:0] st, logic fin);
         rsp_type r;
         r.out_symbol   = sym;
         r.symbol_valid = hit;
         r.status       = st;
         r.last         = fin;
         return r;
      endfunction

      // append one result to the tail of the due queue
      function void add_due(rsp_type r);
         due_results = {due_results, r};
      endfunction

      // Follow the existing path first, then create the rest only if it fits.
      function logic [STATUS_W-1:0] insert_code(logic [SYM_W-1:0] sym,
                                                logic [LEN_W-1:0] len,
                                                logic [CODE_W-1:0] bits);
         int                node;
         int                depth;
         int                i;
         logic              open;
         logic [NODE_W-1:0] child;
         if (len == 0 || len > MAX_CODE_LEN) return ST_TOO_LONG;
         node  = 0;
         depth = 0;
         open  = 1'b1;
         while (open && depth < len) begin
            child = bits[len-1-depth] ? right_of[node] : left_of[node];
            if (child == 0) begin
               open = 1'b0;
            end else begin
               node  = child;
               depth = depth + 1;
            end
         end
         if (node_fill + (len - depth) > NODE_COUNT) return ST_FULL;
         for (i = depth; i < len; i++) begin
            left_of[node_fill]   = '0;
            right_of[node_fill]  = '0;
            symbol_at[node_fill] = '0;
            if (bits[len-1-i]) right_of[node] = NODE_W'(node_fill);
            else               left_of[node]  = NODE_W'(node_fill);
            node      = node_fill;
            node_fill = node_fill + 1;
         end
         symbol_at[node] = sym;
         return ST_OK;
      endfunction

      // Walk the leading bits of one byte; the walk position carries over.
      function void walk_byte(logic [BYTE_BITS-1:0] data, logic [CNT_W-1:0] cnt);
         rsp_type           found[BYTE_BITS];
         int                n;
         int                used;
         int                j;
         logic [NODE_W-1:0] child;
         n    = 0;
         used = (cnt > BYTE_BITS) ? BYTE_BITS : cnt;
         for (j = 0; j < used; j++) begin
            child = data[BYTE_BITS-1-j] ? right_of[walk_at] : left_of[walk_at];
            if (child == 0) begin
               found[n] = make_result('0, 1'b0, ST_MISSING, 1'b0);
               n        = n + 1;
               walk_at  = '0;
            end else if (left_of[child] == 0 && right_of[child] == 0) begin
               found[n] = make_result(symbol_at[child], 1'b1, ST_OK, 1'b0);
               n        = n + 1;
               walk_at  = '0;
            end else begin
               walk_at = child;
            end
         end
         if (n == 0) begin
            add_due(make_result('0, 1'b0, ST_OK, 1'b1));
         end else begin
            found[n-1].last = 1'b1;
            for (j = 0; j < n; j++) add_due(found[j]);
         end
      endfunction

      function void take_item(req_type item);
         items_seen = items_seen + 1;
         case (item.func)
            FUNC_CLEAR: begin
               wipe_tree();
               add_due(make_result('0, 1'b0, ST_OK, 1'b1));
            end
            FUNC_LOAD: begin
               add_due(make_result('0, 1'b0,
                  insert_code(item.symbol, item.code_len, item.code_bits), 1'b1));
            end
            FUNC_DECODE: begin
               decodes_seen = decodes_seen + 1;
               walk_byte(item.data_byte, item.bit_count);
            end
            default: begin
               add_due(make_result('0, 1'b0, ST_OK, 1'b1));
            end
         endcase
      endfunction

      task report_mismatch(string what, rsp_type want, rsp_type got);
         mismatches = mismatches + 1;
         $display("[%0t] MISMATCH %s: want %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
                  $time, what, want.out_symbol, want.symbol_valid, want.status,
                  want.last, got.out_symbol, got.symbol_valid, got.status, got.last);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            report_mismatch("result with nothing due", '0, got);
            return;
         end
         want = due_results.pop_front();
         status_seen[want.status] = status_seen[want.status] + 1;
         if (want.symbol_valid) symbols_seen = symbols_seen + 1;
         if (got.out_symbol !== want.out_symbol || got.symbol_valid !== want.symbol_valid ||
             got.status !== want.status || got.last !== want.last)
            report_mismatch("field", want, got);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block and its signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   tree_scoreboard board;

   // sender burst bookkeeping
   int burst_left  = 0;
   // receiver pattern bookkeeping
   int stall_mode  = STALL_NONE;
   int mode_left   = 0;
   int run_left    = 0;
   logic run_stall = 1'b0;
   // watchdog
   int quiet_cycles = 0;

   huffman_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Item builders; fields an operation ignores still get random values
   // -------------------------------------------------------------------------
   function automatic req_type plain_item(logic [FUNC_W-1:0] func);
      req_type item;
      item.func      = func;
      item.symbol    = SYM_W'($urandom);
      item.code_len  = LEN_W'($urandom);
      item.code_bits = $urandom;
      item.data_byte = BYTE_BITS'($urandom);
      item.bit_count = CNT_W'($urandom);
      return item;
   endfunction

   function automatic req_type load_item(logic [SYM_W-1:0] sym, logic [LEN_W-1:0] len,
                                         logic [CODE_W-1:0] bits);
      req_type item;
      item           = plain_item(FUNC_LOAD);
      item.symbol    = sym;
      item.code_len  = len;
      item.code_bits = bits;
      return item;
   endfunction

   function automatic req_type decode_item(logic [BYTE_BITS-1:0] data,
                                           logic [CNT_W-1:0] cnt);
      req_type item;
      item           = plain_item(FUNC_DECODE);
      item.data_byte = data;
      item.bit_count = cnt;
      return item;
   endfunction

   // -------------------------------------------------------------------------
   // Sender: bursts of random length with random gaps in between. Call only
   // right after a rising edge; valid stays high across back-to-back items.
   // -------------------------------------------------------------------------
   task automatic send_item(req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left = burst_left - 1;
      req_valid <= 1'b1;
      req_data  <= item;
      // hold the payload until the transfer happens
      do @(posedge clock); while (req_stall);
      board.take_item(item);
   endtask

   // Drop valid and hold off until every due result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.due_results.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // One well-formed session: optionally clear, load a prefix code built by
   // splitting leaves, then decode a short stream with a padded last byte.
   // -------------------------------------------------------------------------
   task automatic run_code_session();
      logic [CODE_W-1:0] codes[$];
      int                lens[$];
      logic [CODE_W-1:0] c;
      logic [CODE_W-1:0] garbage;
      int                l;
      int                k;
      int                pick;
      int                limit_len;
      int                nbytes;
      int                i;
      logic [CNT_W-1:0]  cnt;
      codes     = {CODE_W'(0), CODE_W'(1)};
      lens      = {1, 1};
      k         = $urandom_range(2, 8);
      limit_len = ($urandom_range(0, 4) == 0) ? 12 : 6;
      while (codes.size() < k) begin
         pick = $urandom_range(0, codes.size() - 1);
         if (lens[pick] < limit_len) begin
            c = codes[pick];
            l = lens[pick];
            codes.delete(pick);
            lens.delete(pick);
            codes = {codes, {c[CODE_W-2:0], 1'b0}, {c[CODE_W-2:0], 1'b1}};
            lens  = {lens, l + 1, l + 1};
         end
      end
      // leave a hole in the tree now and then so decodes hit missing children
      if ($urandom_range(0, 3) == 0) begin
         pick = $urandom_range(0, codes.size() - 1);
         codes.delete(pick);
         lens.delete(pick);
      end
      if ($urandom_range(0, 4) != 0) send_item(plain_item(FUNC_CLEAR));
      for (i = 0; i < codes.size(); i++) begin
         // junk above the code length must be ignored
         garbage = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
         send_item(load_item(SYM_W'($urandom), LEN_W'(lens[i]),
                             codes[i] | (garbage << lens[i])));
      end
      nbytes = $urandom_range(3, 10);
      for (i = 0; i < nbytes; i++) begin
         if (i == nbytes - 1)             cnt = CNT_W'($urandom_range(1, 8));
         else if ($urandom_range(0, 9) == 0) cnt = CNT_W'($urandom_range(0, 15));
         else                             cnt = CNT_W'(BYTE_BITS);
         send_item(decode_item(BYTE_BITS'($urandom), cnt));
      end
   endtask

   // Noise item: any func, every field over its full width.
   function automatic req_type noise_item();
      req_type item;
      int      pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)      item = plain_item(FUNC_DECODE);
      else if (pick < 7) item = plain_item(FUNC_LOAD);
      else if (pick < 8) item = plain_item(FUNC_CLEAR);
      else               item = plain_item(FUNC_UNUSED);
      return item;
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: check each result transfer, then pick the next stall value.
   // The pattern switches between no stall, sparse stalls and long runs.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
            mode_left  = $urandom_range(40, 150);
         end
         mode_left = mode_left - 1;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_SPRINKLE: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               if (run_left == 0) begin
                  run_stall = ~run_stall;
                  run_left  = run_stall ? $urandom_range(1, 15) : $urandom_range(1, 5);
               end
               run_left = run_left - 1;
               rsp_stall <= run_stall;
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when nothing transfers on either channel for long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int   i;
      int   random_start;
      logic paused_once;
      board       = new();
      paused_once = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: unused func, walk over an empty tree (eight missing children)
      send_item(plain_item(FUNC_UNUSED));
      send_item(decode_item(8'hA5, 4'd8));
      // zero length and over-long codes leave the tree alone
      send_item(load_item(7'd3, 6'd0, '1));
      send_item(load_item(7'd3, 6'd33, '1));
      // small complete code: 0 -> 0, 10 -> 127, 11 -> 5 (junk above bit 1)
      send_item(load_item(7'd0, 6'd1, 32'h0));
      send_item(load_item(7'd127, 6'd2, 32'h2));
      send_item(load_item(7'd5, 6'd2, 32'hFFFF_FFFF));
      // eight symbols from one byte, no bits used, count above eight saturating
      send_item(decode_item(8'h00, 4'd8));
      send_item(decode_item(8'hFF, 4'd0));
      send_item(decode_item(8'hB4, 4'd15));
      // a code spanning two items
      send_item(decode_item(8'h80, 4'd1));
      send_item(decode_item(8'h40, 4'd1));
      // prefix overlap: rewrite an inner node, which must never act as a leaf
      send_item(load_item(7'd9, 6'd1, 32'h1));
      send_item(decode_item(8'h80, 4'd1));
      send_item(decode_item(8'hFF, 4'd8));
      send_item(plain_item(FUNC_CLEAR));
      // fill the store: eight 32-bit codes use 247 of 256 nodes
      for (i = 0; i < 8; i++)
         send_item(load_item(SYM_W'(i), 6'd32, CODE_W'(i) << 29));
      // needs 29 more nodes: full; the next needs exactly the 9 left
      send_item(load_item(7'd1, 6'd32, 32'hFFFF_FFFF));
      send_item(load_item(7'd127, 6'd12, 32'h0000_0F00));
      // one new node on a full store, then a path that needs none
      send_item(load_item(7'd2, 6'd5, 32'h0000_001F));
      send_item(load_item(7'd42, 6'd3, 32'h0000_0007));
      send_item(decode_item(8'hF0, 4'd8));
      send_item(decode_item(8'h00, 4'd4));

      // pause until every due result is back before the random part
      wait_for_results();

      // Random: mostly well-formed sessions, the rest noise
      random_start = board.items_seen;
      while (board.items_seen < random_start + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) run_code_session();
         else                          send_item(noise_item());
         if (!paused_once && board.items_seen >= random_start + MID_PAUSE_AT) begin
            wait_for_results();
            paused_once = 1'b1;
         end
      end

      // drain, then give the block time to show any stray result
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.due_results.size() != 0)
         board.report_mismatch("expected result never came", board.due_results[0], '0);

      $display("Covered %0d items including %0d decodes; %0d symbols decoded.",
               board.items_seen, board.decodes_seen, board.symbols_seen);
      $display("Status ok %0d, missing %0d, full %0d, bad length %0d; %0d mismatches.",
               board.status_seen[ST_OK], board.status_seen[ST_MISSING],
               board.status_seen[ST_FULL], board.status_seen[ST_TOO_LONG],
               board.mismatches);
      if (board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
